FILE: design/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

    // Build-time defaults
    localparam int SLOTS_DEFAULT = 64;

    // Fixed field widths
    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 13;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 3;
    localparam int OUT_IDX_W = 6;

    // Serial divider: one quotient bit per step over the 32-bit offset
    localparam int DIV_STEPS = ADDR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Register reset values
    localparam logic [ADDR_W-1:0]  BASE_RESET  = '0;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 13'd1;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    // Register indexes (word address bits)
    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_SIZE  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    // Request kinds
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED  = 3'd0,
        ST_FREED      = 3'd1,
        ST_EXHAUSTED  = 3'd2,
        ST_NULL       = 3'd3,
        ST_MISALIGNED = 3'd4,
        ST_RANGE      = 3'd5
    } status_t;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_OFFS = 6'b000100,
        S_DIV  = 6'b001000,
        S_CHK  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

endpackage

`default_nettype wire

FILE: design/fixed_block_pool_allocator_unit.sv
// Fixed-size block pool allocator. One free flag per slot, all set at reset
// (flip-flops, no clearing pass). An allocate request (tuser 0) returns the
// lowest free slot among the first min(slot_count, SLOTS) and its address
// base_address + index * object_size; a free request (tuser 1) checks the
// address and frees its slot. Each request gives exactly one result, with
// the status on m_axis_tuser. Requests are handled one at a time through a
// small sequencer around a single shared 32-bit adder. An allocate scans
// the slots in use from index 0 (one slot per cycle) until it finds a free
// one or runs out; a free of a non-zero address at or above the base goes
// through the 32-step restoring divider, which checks alignment and finds
// the slot index; a zero address skips the divider and gets a null result,
// and a below-base one is rejected by the offset subtraction. A finished
// result waits in an output register while the next request is accepted;
// if that register is still full, the sequencer holds its result and the
// input until the receiver takes it.
// Registers sit at byte addresses 0 (base_address), 4 (object_size) and
// 8 (slot_count); write them only while no request is in flight.
`default_nettype none

module fixed_block_pool_allocator_unit #(
    parameter int SLOTS = fbpa_pkg::SLOTS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] address
    input  wire logic [0:0]  s_axis_tuser,   // [0] func

    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] slot_address, [37:32] slot_index
    output logic [2:0]       m_axis_tuser,   // [2:0] status

    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CW    = (CNT_W > fbpa_pkg::COUNT_W) ? CNT_W : fbpa_pkg::COUNT_W;
    localparam int AW    = fbpa_pkg::ADDR_W;
    localparam int SW    = fbpa_pkg::SIZE_W;

    // Configuration registers
    logic [AW-1:0]                base_reg;
    logic [SW-1:0]                size_reg;
    logic [fbpa_pkg::COUNT_W-1:0] count_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= fbpa_pkg::BASE_RESET;
            size_reg  <= fbpa_pkg::SIZE_RESET;
            count_reg <= fbpa_pkg::COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            priority case (paddr[3:2])
                fbpa_pkg::REG_BASE:  base_reg  <= pwdata;
                fbpa_pkg::REG_SIZE:  size_reg  <= pwdata[SW-1:0];
                fbpa_pkg::REG_COUNT: count_reg <= pwdata[fbpa_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            fbpa_pkg::REG_BASE:  prdata = base_reg;
            fbpa_pkg::REG_SIZE:  prdata = 32'(size_reg);
            fbpa_pkg::REG_COUNT: prdata = 32'(count_reg);
            default:             prdata = '0;
        endcase
    end

    // Effective size and slots in use
    logic [SW-1:0] size_eff;
    logic [CW-1:0] count_use;

    assign size_eff  = (size_reg == '0) ? SW'(1) : size_reg;
    assign count_use = (CW'(count_reg) < CW'(SLOTS)) ? CW'(count_reg) : CW'(SLOTS);

    // Sequencer and datapath registers
    fbpa_pkg::state_t             state_reg, state_next;
    logic [CNT_W-1:0]             scan_reg, scan_next;
    logic [AW-1:0]                work_reg, work_next;    // running address / quotient
    logic [SW-1:0]                rem_reg, rem_next;
    logic [fbpa_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [SLOTS-1:0]             free_reg, free_next;
    fbpa_pkg::status_t            res_status_reg, res_status_next;
    logic [AW-1:0]                res_addr_reg, res_addr_next;
    logic [fbpa_pkg::OUT_IDX_W-1:0] res_idx_reg, res_idx_next;

    // Output register
    logic                         out_valid_reg, out_valid_next;
    fbpa_pkg::status_t            out_status_reg, out_status_next;
    logic [AW-1:0]                out_addr_reg, out_addr_next;
    logic [fbpa_pkg::OUT_IDX_W-1:0] out_idx_reg, out_idx_next;

    // Shared adder / subtractor
    logic [AW-1:0] alu_a, alu_b;
    logic          alu_sub;
    logic [AW:0]   alu_sum;
    logic [SW:0]   div_shift;

    assign div_shift = {rem_reg, work_reg[AW-1]};

    always_comb
    begin
        unique case (state_reg)
            fbpa_pkg::S_SCAN:
            begin
                alu_a   = work_reg;
                alu_b   = AW'(size_eff);
                alu_sub = 1'b0;
            end
            fbpa_pkg::S_OFFS:
            begin
                alu_a   = work_reg;
                alu_b   = base_reg;
                alu_sub = 1'b1;
            end
            fbpa_pkg::S_DIV:
            begin
                alu_a   = AW'(div_shift);
                alu_b   = AW'(size_eff);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = work_reg;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    // Carry out set on a subtraction means no borrow
    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_sub ? ~alu_b : alu_b} + (AW+1)'(alu_sub);

    logic out_load;
    logic scan_end;
    logic scan_free;

    assign s_axis_tready = (state_reg == fbpa_pkg::S_IDLE);
    assign out_load  = (state_reg == fbpa_pkg::S_OUT) && (!out_valid_reg || m_axis_tready);
    assign scan_end  = (CW'(scan_reg) >= count_use);
    assign scan_free = free_reg[scan_reg[IDX_W-1:0]];

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        work_next       = work_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        free_next       = free_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_idx_next    = res_idx_reg;

        unique case (state_reg)
            fbpa_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    scan_next = '0;
                    if (s_axis_tuser[0] == fbpa_pkg::FUNC_ALLOC)
                    begin
                        work_next  = base_reg;
                        state_next = fbpa_pkg::S_SCAN;
                    end
                    else if (s_axis_tdata == '0)
                    begin
                        res_status_next = fbpa_pkg::ST_NULL;
                        res_addr_next   = '0;
                        res_idx_next    = '0;
                        state_next      = fbpa_pkg::S_OUT;
                    end
                    else
                    begin
                        work_next  = s_axis_tdata;
                        state_next = fbpa_pkg::S_OFFS;
                    end
                end
            end

            // One slot per cycle, address advanced by one object size
            fbpa_pkg::S_SCAN:
            begin
                if (scan_end)
                begin
                    res_status_next = fbpa_pkg::ST_EXHAUSTED;
                    res_addr_next   = '0;
                    res_idx_next    = '0;
                    state_next      = fbpa_pkg::S_OUT;
                end
                else if (scan_free)
                begin
                    free_next[scan_reg[IDX_W-1:0]] = 1'b0;
                    res_status_next = fbpa_pkg::ST_ALLOCATED;
                    res_addr_next   = work_reg;
                    res_idx_next    = fbpa_pkg::OUT_IDX_W'(scan_reg);
                    state_next      = fbpa_pkg::S_OUT;
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                    work_next = alu_sum[AW-1:0];
                end
            end

            // Offset from base; a borrow means below base
            fbpa_pkg::S_OFFS:
            begin
                if (!alu_sum[AW])
                begin
                    res_status_next = fbpa_pkg::ST_RANGE;
                    res_addr_next   = '0;
                    res_idx_next    = '0;
                    state_next      = fbpa_pkg::S_OUT;
                end
                else
                begin
                    work_next    = alu_sum[AW-1:0];
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = fbpa_pkg::S_DIV;
                end
            end

            // Restoring divide, quotient shifts in where the dividend shifts out
            fbpa_pkg::S_DIV:
            begin
                if (alu_sum[AW])
                    rem_next = alu_sum[SW-1:0];
                else
                    rem_next = div_shift[SW-1:0];
                work_next    = {work_reg[AW-2:0], alu_sum[AW]};
                div_cnt_next = div_cnt_reg + fbpa_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == fbpa_pkg::DIV_CNT_W'(fbpa_pkg::DIV_STEPS - 1))
                    state_next = fbpa_pkg::S_CHK;
            end

            fbpa_pkg::S_CHK:
            begin
                res_addr_next = '0;
                if (rem_reg != '0)
                begin
                    res_status_next = fbpa_pkg::ST_MISALIGNED;
                    res_idx_next    = '0;
                end
                else if (work_reg >= AW'(count_use))
                begin
                    res_status_next = fbpa_pkg::ST_RANGE;
                    res_idx_next    = '0;
                end
                else
                begin
                    free_next[work_reg[IDX_W-1:0]] = 1'b1;
                    res_status_next = fbpa_pkg::ST_FREED;
                    res_idx_next    = fbpa_pkg::OUT_IDX_W'(work_reg);
                end
                state_next = fbpa_pkg::S_OUT;
            end

            fbpa_pkg::S_OUT:
            begin
                if (out_load)
                    state_next = fbpa_pkg::S_IDLE;
            end

            default:
            begin
                state_next = fbpa_pkg::S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_idx_next    = out_idx_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_addr_next   = res_addr_reg;
            out_idx_next    = res_idx_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbpa_pkg::S_IDLE;
            free_reg      <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        work_reg       <= work_next;
        rem_reg        <= rem_next;
        div_cnt_reg    <= div_cnt_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_idx_reg    <= res_idx_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_idx_reg    <= out_idx_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {2'b00, out_idx_reg, out_addr_reg};

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while a request was in flight");

    a_rem_below_size: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fbpa_pkg::S_CHK) |-> (rem_reg < size_eff))
        else $error("divider remainder not below object size");

    a_result_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fbpa_pkg::S_OUT && (!out_valid_reg || m_axis_tready))
        |=> (m_axis_tvalid && s_axis_tready))
        else $error("finished result not moved to the output register");

endmodule

`default_nettype wire

FILE: sim/fixed_block_pool_allocator_checker.sv
`default_nettype none

module fixed_block_pool_allocator_checker
    import fbpa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] address
    input  wire logic [0:0]  s_axis_tuser,   // [0] func
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,   // [31:0] slot_address, [37:32] slot_index
    input  wire logic [2:0]  m_axis_tuser,   // [2:0] status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               mismatches,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t     status;
        logic [31:0] slot_address;
        logic [5:0]  slot_index;
    } pool_reply_t;

    // Shadow of the pool registers and free flags
    logic [ADDR_W-1:0]  pool_base  = BASE_RESET;
    logic [SIZE_W-1:0]  pool_size  = SIZE_RESET;
    logic [COUNT_W-1:0] pool_count = COUNT_RESET;
    logic [SLOTS-1:0]   free_marks = '1;

    pool_reply_t replies_due[$];
    int          error_total = 0;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Reply of the pool to one request, updating the free flags
    function automatic pool_reply_t serve_request(input logic func, input logic [31:0] address);
        pool_reply_t reply;
        int unsigned in_use;
        logic [31:0] spacing;
        logic [31:0] offset;
        logic [31:0] idx;
        int          i;
        bit          found;
        reply.status       = ST_EXHAUSTED;
        reply.slot_address = '0;
        reply.slot_index   = '0;
        in_use  = (pool_count < SLOTS) ? pool_count : SLOTS;
        spacing = (pool_size == '0) ? 32'd1 : 32'(pool_size);
        found   = 1'b0;
        if (func == FUNC_ALLOC)
        begin
            // lowest free slot among those in use
            for (i = 0; i < in_use && !found; i++)
            begin
                if (free_marks[i])
                begin
                    free_marks[i]      = 1'b0;
                    reply.status       = ST_ALLOCATED;
                    reply.slot_address = pool_base + 32'(i) * spacing;
                    reply.slot_index   = 6'(i);
                    found              = 1'b1;
                end
            end
        end
        else if (address == '0)
            reply.status = ST_NULL;
        else if (address < pool_base)
            reply.status = ST_RANGE;
        else
        begin
            offset = address - pool_base;
            if (offset % spacing != 0)
                reply.status = ST_MISALIGNED;
            else
            begin
                idx = offset / spacing;
                if (idx >= in_use)
                    reply.status = ST_RANGE;
                else
                begin
                    free_marks[idx]  = 1'b1;
                    reply.status     = ST_FREED;
                    reply.slot_index = idx[5:0];
                end
            end
        end
        return reply;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            error_total++;
        end
    endtask

    // Compare results, queue predictions and track register writes
    always @(posedge clk or negedge rst_n)
    begin
        pool_reply_t want;
        if (!rst_n)
        begin
            pool_base  = BASE_RESET;
            pool_size  = SIZE_RESET;
            pool_count = COUNT_RESET;
            free_marks = '1;
            replies_due.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t ns: unexpected result transaction, expected none, got status %0d address %h index %0d",
                             $time, m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[37:32]);
                    error_total++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    check_field("status", 32'(want.status), 32'(m_axis_tuser));
                    check_field("slot_address", want.slot_address, m_axis_tdata[31:0]);
                    check_field("slot_index", 32'(want.slot_index), 32'(m_axis_tdata[37:32]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                replies_due.push_back(serve_request(s_axis_tuser[0], s_axis_tdata));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_BASE:  pool_base  = pwdata;
                    REG_SIZE:  pool_size  = pwdata[SIZE_W-1:0];
                    REG_COUNT: pool_count = pwdata[COUNT_W-1:0];
                    default:   ;
                endcase
            end
        end
        mismatches  <= error_total;
        outstanding <= replies_due.size();
    end

endmodule

`default_nettype wire

FILE: sim/fixed_block_pool_allocator_unit_test.sv
`default_nettype none

module fixed_block_pool_allocator_unit_test;
    import fbpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SLOTS  = SLOTS_DEFAULT;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 500;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;     // [31:0] address
    logic [0:0]  s_axis_tuser  = '0;     // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [31:0] slot_address, [37:32] slot_index
    logic [2:0]  m_axis_tuser;           // [2:0] status
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending_results;

    // Idle rates in percent, and the long receiver hold-off
    int src_idle    = 0;
    int sink_stall  = 0;
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int cycle_count  = 0;

    // Pool settings as last written, used to aim the requests
    logic [31:0] cur_base  = BASE_RESET;
    logic [12:0] cur_size  = SIZE_RESET;
    logic [6:0]  cur_count = COUNT_RESET;

    fixed_block_pool_allocator_unit #(
        .SLOTS(POOL_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    fixed_block_pool_allocator_checker #(
        .SLOTS(POOL_SLOTS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .pready(pready),
        .mismatches(fail_count),
        .outstanding(pending_results)
    );

    always #10 clk = ~clk;

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure_pool(input logic [31:0] base, input logic [12:0] size,
                                  input logic [6:0] count);
        write_register(REG_BASE, base);
        write_register(REG_SIZE, 32'(size));
        write_register(REG_COUNT, 32'(count));
        cur_base  = base;
        cur_size  = size;
        cur_count = count;
    endtask

    // One request transaction, with optional idle cycles before it
    task automatic send_request(input logic func, input logic [31:0] address);
        if ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= address;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drop the request and wait for every result to drain
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    // Mostly allocations and frees of real slots, the rest bad addresses
    task automatic send_random_request();
        int          pick;
        int          in_use;
        int          idx;
        logic [31:0] spacing;
        logic [31:0] address;
        pick    = $urandom_range(99);
        in_use  = (cur_count > POOL_SLOTS) ? POOL_SLOTS : cur_count;
        spacing = (cur_size == '0) ? 32'd1 : 32'(cur_size);
        idx     = (in_use > 0) ? $urandom_range(in_use - 1) : 0;
        if (pick < 45)
            send_request(FUNC_ALLOC, $urandom);
        else if (pick < 80 && in_use > 0)
            send_request(FUNC_FREE, cur_base + 32'(idx) * spacing);
        else
        begin
            case ($urandom_range(4))
                0: address = '0;
                1: address = $urandom;
                2: address = (spacing > 1) ? cur_base + 32'(idx) * spacing
                                             + $urandom_range(32'(spacing) - 1, 1)
                                           : $urandom;
                3: address = cur_base - $urandom_range(64, 1);
                default: address = cur_base + 32'(in_use + $urandom_range(3)) * spacing;
            endcase
            send_request(FUNC_FREE, address);
        end
    endtask

    task automatic run_random_phase(input logic [31:0] base, input logic [12:0] size,
                                    input logic [6:0] count, input int src, input int sink,
                                    input int items, input bit hold);
        configure_pool(base, size, count);
        src_idle   = src;
        sink_stall = sink;
        if (hold)
            hold_request = 1'b1;
        repeat (items)
            send_random_request();
        wait_idle();
    endtask

    // Directed cases: every status, exhaustion, odd register values, wrap
    task automatic run_directed();
        src_idle   = 0;
        sink_stall = 0;
        configure_pool(32'h0000_1000, 13'd16, 7'd4);
        repeat (5)
            send_request(FUNC_ALLOC, 32'hFFFF_FFFF);
        send_request(FUNC_FREE, 32'h0000_0000);      // null pointer
        send_request(FUNC_FREE, 32'h0000_0FF0);      // below base
        send_request(FUNC_FREE, 32'h0000_1008);      // not on a slot boundary
        send_request(FUNC_FREE, 32'h0000_1040);      // one past the last slot
        send_request(FUNC_FREE, 32'h0000_1010);
        send_request(FUNC_FREE, 32'h0000_1010);      // already free
        send_request(FUNC_ALLOC, 32'h0000_0000);
        send_request(FUNC_FREE, 32'hFFFF_FFFF);
        wait_idle();

        // no slots in use
        configure_pool(32'h0000_1000, 13'd16, 7'd0);
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_FREE, 32'h0000_1000);
        wait_idle();

        // zero size acts as one, count beyond the built pool
        configure_pool(32'hFFFF_FFF0, 13'd0, 7'd127);
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_FREE, 32'hFFFF_FFF4);
        send_request(FUNC_FREE, 32'hFFFF_FFFF);
        send_request(FUNC_ALLOC, 32'h0);
        wait_idle();

        // largest size, addresses wrapping past the top
        configure_pool(32'hFFFF_0000, 13'h1FFF, 7'd64);
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_FREE, 32'hFFFF_0000 + 32'd40 * 32'h1FFF);
        wait_idle();
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        run_random_phase(32'h0000_0000, 13'd1,    7'd64,  0,  0,  160, 1'b0);
        run_random_phase(32'h8000_0000, 13'd4096, 7'd64,  67, 0,  150, 1'b0);
        run_random_phase($urandom, 13'($urandom_range(4096, 1)), 7'($urandom_range(64, 1)),
                         0, 67, 150, 1'b0);
        run_random_phase(32'hFFFF_FF00, 13'h1FFF, 7'd64,  10, 10, 150, 1'b0);
        run_random_phase(32'h0000_0010, 13'd0,    7'd127, 0,  0,  150, 1'b1);
        run_random_phase(32'h1234_5670, 13'd3,    7'd1,   10, 10, 120, 1'b0);
        run_random_phase($urandom,      13'd8,    7'd0,   0,  67, 60,  1'b0);
        run_random_phase(32'hFFFF_FFFF, 13'd1,    7'd64,  67, 0,  120, 1'b0);
        run_random_phase($urandom, 13'($urandom_range(64, 1)), 7'd8, 10, 10, 150, 1'b0);

        wait_idle();
        repeat (40)
            @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
